FILE: hdl/sampson_error_from_parameters_assert.svh
`ifndef SAMPSON_ERROR_FROM_PARAMETERS_ASSERT_SVH
`define SAMPSON_ERROR_FROM_PARAMETERS_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SEFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SEFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sefp_pkg.sv
package sefp_pkg;

    // Fixed-point format and datapath widths.
    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int ACC_W     = 68;
    localparam int NUM_W     = DW + FRAC_BITS;

    // Square root: a 66-bit radicand yields one result bit per stage.
    localparam int SQ_IN_W   = 66;
    localparam int SQ_STAGES = SQ_IN_W / 2;
    localparam int ROOT_W    = SQ_STAGES;
    localparam int REM_W     = ROOT_W + 3;

    // Division: one quotient bit per stage.
    localparam int DIV_STAGES = DW;

    // Cycles the matrix rebuild needs after a register write.
    localparam int CFG_SETTLE = 5;
    localparam int CNT_W      = $clog2(CFG_SETTLE + 1);

    localparam logic signed [DW-1:0] ONE_Q = DW'(64'd1 << FRAC_BITS);
    localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(32'sh7FFFFFFF);
    localparam logic signed [ACC_W-1:0] Q_MIN = ACC_W'(32'sh80000000);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_FREE_A     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREE_B     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FREE_C     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_W1     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_W2     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COL_W1     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COL_W2     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_POSITIONS  = 4'd7;
    localparam logic [7:0]           POS_RESET      = 8'd80;

    typedef logic signed [DW-1:0] q_t;
    typedef q_t fmat_t [9];

    // Item leaving the line stages toward the square root.
    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic                 sat;
        logic [DW-1:0]        anum;
        logic [SQ_IN_W-2:0]   sum;
    } sq_in_t;

    // Item leaving the square root toward the divider.
    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic                 sat;
        logic [DW-1:0]        anum;
        logic [ROOT_W-1:0]    root;
    } div_in_t;

    // Finished result.
    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic                 flag;
        logic [DW-1:0]        err;
    } res_t;

    // Flat index of matrix entry (r, c).
    function automatic logic [3:0] fidx(input logic [1:0] r, input logic [1:0] c);
        return {2'b00, r} * 4'd3 + {2'b00, c};
    endfunction

    // Floor to the fixed-point grid and saturate to 32 signed bits.
    function automatic q_t sat_q(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        s = v >>> FRAC_BITS;
        if (s > Q_MAX) begin
            return Q_MAX[DW-1:0];
        end
        if (s < Q_MIN) begin
            return Q_MIN[DW-1:0];
        end
        return s[DW-1:0];
    endfunction

    // True when the floored value does not fit in 32 signed bits.
    function automatic logic ovf_q(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        s = v >>> FRAC_BITS;
        return (s > Q_MAX) || (s < Q_MIN);
    endfunction

endpackage

FILE: hdl/sampson_error_from_parameters.sv
// Channel   Handshake                       Payload
// s_axis    s_axis_tvalid / s_axis_tready   tdata first_x..second_y, tlast last_pair
// m_axis    m_axis_tvalid / m_axis_tready   tdata sampson_error, tuser degenerate_flag,
//                                           tlast last_error
// cfg       cfg_valid / cfg_ready           cfg_index register, cfg_data value
//
// One correspondence per cycle unless stalled; each passes five line stages, 33 square
// root stages (one root bit each) and 33 divider stages (range check, one quotient
// bit each). After reset and after every register write, the matrix rebuild keeps
// s_axis_tready low while it runs. A stalled m_axis freezes the whole pipeline.
module sampson_error_from_parameters (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [127:0]                    s_axis_tdata,  // first_x, first_y, second_x, second_y
    input  logic                            s_axis_tlast,  // last_pair
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [sefp_pkg::DW-1:0]         m_axis_tdata,  // sampson_error
    output logic                            m_axis_tuser,  // degenerate_flag
    output logic                            m_axis_tlast,  // last_error
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sefp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sefp_pkg::DW-1:0]         cfg_data
);
    import sefp_pkg::*;

    fmat_t   fmat;
    logic    fmat_sat;
    logic    busy;
    logic    adv;
    sq_in_t  line_item;
    div_in_t root_item;
    res_t    res;

    // The pipeline moves whenever the output register is free or being taken.
    assign adv           = !res.valid || m_axis_tready;
    assign s_axis_tready = adv && !busy;

    sefp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fmat      (fmat),
        .fmat_sat  (fmat_sat),
        .busy      (busy)
    );

    sefp_lines u_lines (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (s_axis_tvalid && s_axis_tready),
        .in_x0    (s_axis_tdata[31:0]),
        .in_y0    (s_axis_tdata[63:32]),
        .in_x1    (s_axis_tdata[95:64]),
        .in_y1    (s_axis_tdata[127:96]),
        .in_last  (s_axis_tlast),
        .fmat     (fmat),
        .fmat_sat (fmat_sat),
        .out_item (line_item)
    );

    sefp_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_item  (line_item),
        .out_item (root_item)
    );

    sefp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_item  (root_item),
        .out_item (res)
    );

    assign m_axis_tvalid = res.valid;
    assign m_axis_tdata  = res.err;
    assign m_axis_tuser  = res.flag;
    assign m_axis_tlast  = res.last;

endmodule

FILE: hdl/sefp_cfg.sv
module sefp_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sefp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sefp_pkg::DW-1:0]         cfg_data,
    output sefp_pkg::fmat_t                 fmat,
    output logic                            fmat_sat,
    output logic                            busy
);
    import sefp_pkg::*;

    q_t         free_a_reg, free_b_reg, free_c_reg;
    q_t         row_w1_reg, row_w2_reg, col_w1_reg, col_w2_reg;
    logic [7:0] pos_reg;
    logic [CNT_W-1:0] busy_reg;

    logic [1:0] id, jd, ur, uc, rr0, rr1, cc0, cc1;
    logic [1:0] slot_r [4];
    logic [1:0] slot_c [4];
    q_t         srcs [4];
    q_t         m [4];
    logic [1:0] nx;

    logic signed [2*DW-1:0] prod_reg [8];
    q_t                     d_reg [4];
    logic                   d_sat_reg;
    logic signed [2*DW-1:0] e_prod_reg [2];
    q_t                     d4_reg;
    logic                   d4_sat_reg;
    q_t                     fm_next [9];
    fmat_t                  fmat_reg;
    logic                   fmat_sat_reg;

    assign cfg_ready = 1'b1;
    assign busy      = (busy_reg != '0);
    assign fmat      = fmat_reg;
    assign fmat_sat  = fmat_sat_reg;

    // Register writes; every write restarts the rebuild countdown.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_a_reg <= '0;
            free_b_reg <= '0;
            free_c_reg <= '0;
            row_w1_reg <= '0;
            row_w2_reg <= '0;
            col_w1_reg <= '0;
            col_w2_reg <= '0;
            pos_reg    <= POS_RESET;
            busy_reg   <= CNT_W'(CFG_SETTLE);
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                busy_reg <= CNT_W'(CFG_SETTLE);
                case (cfg_index)
                    REG_FREE_A:    free_a_reg <= cfg_data;
                    REG_FREE_B:    free_b_reg <= cfg_data;
                    REG_FREE_C:    free_c_reg <= cfg_data;
                    REG_ROW_W1:    row_w1_reg <= cfg_data;
                    REG_ROW_W2:    row_w2_reg <= cfg_data;
                    REG_COL_W1:    col_w1_reg <= cfg_data;
                    REG_COL_W2:    col_w2_reg <= cfg_data;
                    REG_POSITIONS: pos_reg    <= cfg_data[7:0];
                    default:       ;
                endcase
            end
            else if (busy_reg != '0)
            begin
                busy_reg <= busy_reg - CNT_W'(1);
            end
        end
    end

    // Decode positions and fill the four minor slots.
    always_comb
    begin
        id  = (pos_reg[1:0] == 2'd3) ? 2'd2 : pos_reg[1:0];
        jd  = (pos_reg[3:2] == 2'd3) ? 2'd2 : pos_reg[3:2];
        ur  = pos_reg[5:4];
        uc  = pos_reg[7:6];
        rr0 = (id == 2'd0) ? 2'd1 : 2'd0;
        rr1 = (id == 2'd2) ? 2'd1 : 2'd2;
        cc0 = (jd == 2'd0) ? 2'd1 : 2'd0;
        cc1 = (jd == 2'd2) ? 2'd1 : 2'd2;
        srcs[0] = free_a_reg;
        srcs[1] = free_b_reg;
        srcs[2] = free_c_reg;
        srcs[3] = row_w1_reg;
        nx = 2'd0;
        for (int k = 0; k < 4; k++)
        begin
            slot_r[k] = (k < 2) ? rr0 : rr1;
            slot_c[k] = (k == 0 || k == 2) ? cc0 : cc1;
            if (slot_r[k] == ur && slot_c[k] == uc)
            begin
                m[k] = ONE_Q;
            end
            else
            begin
                m[k] = srcs[nx];
                nx   = nx + 2'd1;
            end
        end
    end

    // Matrix assembly from the minor and the derived entries.
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            fm_next[i] = '0;
        end
        for (int k = 0; k < 4; k++)
        begin
            fm_next[fidx(slot_r[k], slot_c[k])] = m[k];
        end
        fm_next[fidx(rr0, jd)] = d_reg[0];
        fm_next[fidx(rr1, jd)] = d_reg[1];
        fm_next[fidx(id, cc0)] = d_reg[2];
        fm_next[fidx(id, cc1)] = d_reg[3];
        fm_next[fidx(id, jd)]  = d4_reg;
    end

    // Rebuild pipeline: products, derived column and row, corner, matrix.
    always_ff @(posedge clk)
    begin
        prod_reg[0] <= m[0] * row_w1_reg;
        prod_reg[1] <= m[1] * row_w2_reg;
        prod_reg[2] <= m[2] * row_w1_reg;
        prod_reg[3] <= m[3] * row_w2_reg;
        prod_reg[4] <= m[0] * col_w1_reg;
        prod_reg[5] <= m[2] * col_w2_reg;
        prod_reg[6] <= m[1] * col_w1_reg;
        prod_reg[7] <= m[3] * col_w2_reg;

        for (int k = 0; k < 4; k++)
        begin
            d_reg[k] <= sat_q(-(ACC_W'(prod_reg[2*k]) + ACC_W'(prod_reg[2*k+1])));
        end
        d_sat_reg <= ovf_q(-(ACC_W'(prod_reg[0]) + ACC_W'(prod_reg[1])))
                   | ovf_q(-(ACC_W'(prod_reg[2]) + ACC_W'(prod_reg[3])))
                   | ovf_q(-(ACC_W'(prod_reg[4]) + ACC_W'(prod_reg[5])))
                   | ovf_q(-(ACC_W'(prod_reg[6]) + ACC_W'(prod_reg[7])));

        e_prod_reg[0] <= d_reg[2] * row_w1_reg;
        e_prod_reg[1] <= d_reg[3] * row_w2_reg;

        d4_reg     <= sat_q(-(ACC_W'(e_prod_reg[0]) + ACC_W'(e_prod_reg[1])));
        d4_sat_reg <= ovf_q(-(ACC_W'(e_prod_reg[0]) + ACC_W'(e_prod_reg[1])))
                    | d_sat_reg;

        fmat_reg     <= fm_next;
        fmat_sat_reg <= d4_sat_reg;
    end

endmodule

FILE: hdl/sefp_lines.sv
module sefp_lines (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  sefp_pkg::q_t      in_x0,
    input  sefp_pkg::q_t      in_y0,
    input  sefp_pkg::q_t      in_x1,
    input  sefp_pkg::q_t      in_y1,
    input  logic              in_last,
    input  sefp_pkg::fmat_t   fmat,
    input  logic              fmat_sat,
    output sefp_pkg::sq_in_t  out_item
);
    import sefp_pkg::*;

    logic [4:0] v_reg;

    q_t   x0_1_reg, y0_1_reg, x1_1_reg, y1_1_reg;
    logic last1_reg;

    logic signed [2*DW-1:0] pa_reg [3];
    logic signed [2*DW-1:0] pb_reg [3];
    logic signed [2*DW-1:0] qa_reg [2];
    logic signed [2*DW-1:0] qb_reg [2];
    q_t   x1_2_reg, y1_2_reg;
    logic last2_reg;

    q_t   l1_reg [3];
    q_t   l0_reg [2];
    logic sat3_reg;
    q_t   x1_3_reg, y1_3_reg;
    logic last3_reg;
    logic signed [ACC_W-1:0] l1_sum [3];
    logic signed [ACC_W-1:0] l0_sum [2];

    logic signed [2*DW-1:0] na_reg, nb_reg;
    q_t   nc_reg;
    logic [2*DW-1:0] sq_reg [4];
    logic sat4_reg, last4_reg;

    logic signed [ACC_W-1:0] num_sum;
    q_t   num;
    logic [DW-1:0] anum5_reg;
    logic [SQ_IN_W-2:0] sum5_reg;
    logic sat5_reg, last5_reg;

    // Valid bits travel with the items.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    // Line and numerator sums before flooring.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            l1_sum[k] = ACC_W'(pa_reg[k]) + ACC_W'(pb_reg[k])
                      + (ACC_W'(fmat[k*3+2]) <<< FRAC_BITS);
        end
        for (int k = 0; k < 2; k++)
        begin
            l0_sum[k] = ACC_W'(qa_reg[k]) + ACC_W'(qb_reg[k])
                      + (ACC_W'(fmat[6+k]) <<< FRAC_BITS);
        end
        num_sum = ACC_W'(na_reg) + ACC_W'(nb_reg) + (ACC_W'(nc_reg) <<< FRAC_BITS);
        num     = sat_q(num_sum);
    end

    // Five payload stages: capture, products, lines, squares, sums.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_1_reg  <= in_x0;
            y0_1_reg  <= in_y0;
            x1_1_reg  <= in_x1;
            y1_1_reg  <= in_y1;
            last1_reg <= in_last;

            for (int k = 0; k < 3; k++)
            begin
                pa_reg[k] <= fmat[k*3]   * x0_1_reg;
                pb_reg[k] <= fmat[k*3+1] * y0_1_reg;
            end
            for (int k = 0; k < 2; k++)
            begin
                qa_reg[k] <= fmat[k]   * x1_1_reg;
                qb_reg[k] <= fmat[3+k] * y1_1_reg;
            end
            x1_2_reg  <= x1_1_reg;
            y1_2_reg  <= y1_1_reg;
            last2_reg <= last1_reg;

            for (int k = 0; k < 3; k++)
            begin
                l1_reg[k] <= sat_q(l1_sum[k]);
            end
            for (int k = 0; k < 2; k++)
            begin
                l0_reg[k] <= sat_q(l0_sum[k]);
            end
            sat3_reg  <= fmat_sat | ovf_q(l1_sum[0]) | ovf_q(l1_sum[1])
                       | ovf_q(l1_sum[2]) | ovf_q(l0_sum[0]) | ovf_q(l0_sum[1]);
            x1_3_reg  <= x1_2_reg;
            y1_3_reg  <= y1_2_reg;
            last3_reg <= last2_reg;

            // Squares are formed at full product width.
            na_reg    <= x1_3_reg * l1_reg[0];
            nb_reg    <= y1_3_reg * l1_reg[1];
            nc_reg    <= l1_reg[2];
            sq_reg[0] <= $unsigned((2*DW)'(l0_reg[0]) * l0_reg[0]);
            sq_reg[1] <= $unsigned((2*DW)'(l0_reg[1]) * l0_reg[1]);
            sq_reg[2] <= $unsigned((2*DW)'(l1_reg[0]) * l1_reg[0]);
            sq_reg[3] <= $unsigned((2*DW)'(l1_reg[1]) * l1_reg[1]);
            sat4_reg  <= sat3_reg;
            last4_reg <= last3_reg;

            anum5_reg <= num[DW-1] ? (~num + DW'(1)) : num;
            sum5_reg  <= (SQ_IN_W-1)'(sq_reg[0]) + (SQ_IN_W-1)'(sq_reg[1])
                       + (SQ_IN_W-1)'(sq_reg[2]) + (SQ_IN_W-1)'(sq_reg[3]);
            sat5_reg  <= sat4_reg | ovf_q(num_sum);
            last5_reg <= last4_reg;
        end
    end

    assign out_item.valid = v_reg[4];
    assign out_item.last  = last5_reg;
    assign out_item.sat   = sat5_reg;
    assign out_item.anum  = anum5_reg;
    assign out_item.sum   = sum5_reg;

endmodule

FILE: hdl/sefp_sqrt.sv
module sefp_sqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  sefp_pkg::sq_in_t   in_item,
    output sefp_pkg::div_in_t  out_item
);
    import sefp_pkg::*;

    logic              v_reg    [SQ_STAGES];
    logic              last_reg [SQ_STAGES];
    logic              sat_reg  [SQ_STAGES];
    logic [DW-1:0]     anum_reg [SQ_STAGES];
    logic [REM_W-1:0]  rem_reg  [SQ_STAGES];
    logic [ROOT_W-1:0] root_reg [SQ_STAGES];
    logic [SQ_IN_W-1:0] val_reg [SQ_STAGES];

    // One result bit per stage, restoring digit-by-digit square root.
    for (genvar s = 0; s < SQ_STAGES; s++)
    begin : g_stage
        logic              v_in, last_in, sat_in;
        logic [DW-1:0]     anum_in;
        logic [REM_W-1:0]  rem_in, rem_sh, trial, rem_n;
        logic [ROOT_W-1:0] root_in, root_n;
        logic [SQ_IN_W-1:0] val_in;

        if (s == 0)
        begin : g_first
            assign v_in    = in_item.valid;
            assign last_in = in_item.last;
            assign sat_in  = in_item.sat;
            assign anum_in = in_item.anum;
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = SQ_IN_W'(in_item.sum);
        end
        else
        begin : g_next
            assign v_in    = v_reg[s-1];
            assign last_in = last_reg[s-1];
            assign sat_in  = sat_reg[s-1];
            assign anum_in = anum_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign val_in  = val_reg[s-1];
        end

        always_comb
        begin
            rem_sh = {rem_in[REM_W-3:0], val_in[SQ_IN_W-1 -: 2]};
            trial  = REM_W'({root_in, 2'b01});
            if (rem_sh >= trial)
            begin
                rem_n  = rem_sh - trial;
                root_n = {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_n  = rem_sh;
                root_n = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                last_reg[s] <= last_in;
                sat_reg[s]  <= sat_in;
                anum_reg[s] <= anum_in;
                rem_reg[s]  <= rem_n;
                root_reg[s] <= root_n;
                val_reg[s]  <= val_in << 2;
            end
        end
    end

    assign out_item.valid = v_reg[SQ_STAGES-1];
    assign out_item.last  = last_reg[SQ_STAGES-1];
    assign out_item.sat   = sat_reg[SQ_STAGES-1];
    assign out_item.anum  = anum_reg[SQ_STAGES-1];
    assign out_item.root  = root_reg[SQ_STAGES-1];

endmodule

FILE: hdl/sefp_div.sv
module sefp_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  sefp_pkg::div_in_t  in_item,
    output sefp_pkg::res_t     out_item
);
    import sefp_pkg::*;

    logic [NUM_W-1:0]  n_wide;
    logic              pre_flag;

    logic              v0_reg, last0_reg, flag0_reg;
    logic [ROOT_W-1:0] root0_reg, rem0_reg;
    logic [DW-1:0]     low0_reg;

    logic              v_reg    [DIV_STAGES];
    logic              last_reg [DIV_STAGES];
    logic              flag_reg [DIV_STAGES];
    logic [ROOT_W-1:0] root_reg [DIV_STAGES];
    logic [ROOT_W-1:0] rem_reg  [DIV_STAGES];
    logic [DW-1:0]     low_reg  [DIV_STAGES];
    logic [DW-1:0]     q_reg    [DIV_STAGES];

    // A quotient of 2^32 or more shows as the high numerator part reaching the root.
    assign n_wide   = {in_item.anum, {FRAC_BITS{1'b0}}};
    assign pre_flag = in_item.sat || (in_item.root == '0)
                   || (ROOT_W'(n_wide[NUM_W-1:DW]) >= in_item.root);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last0_reg <= in_item.last;
            flag0_reg <= pre_flag;
            root0_reg <= in_item.root;
            rem0_reg  <= ROOT_W'(n_wide[NUM_W-1:DW]);
            low0_reg  <= n_wide[DW-1:0];
        end
    end

    // One quotient bit per stage, restoring division.
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic              v_in, last_in, flag_in;
        logic [ROOT_W-1:0] root_in, rem_in, rem_n;
        logic [DW-1:0]     low_in, q_in;
        logic [ROOT_W:0]   rem_sh;
        logic              qbit;

        if (s == 0)
        begin : g_first
            assign v_in    = v0_reg;
            assign last_in = last0_reg;
            assign flag_in = flag0_reg;
            assign root_in = root0_reg;
            assign rem_in  = rem0_reg;
            assign low_in  = low0_reg;
            assign q_in    = '0;
        end
        else
        begin : g_next
            assign v_in    = v_reg[s-1];
            assign last_in = last_reg[s-1];
            assign flag_in = flag_reg[s-1];
            assign root_in = root_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign low_in  = low_reg[s-1];
            assign q_in    = q_reg[s-1];
        end

        always_comb
        begin
            rem_sh = {rem_in, low_in[DW-1]};
            qbit   = (rem_sh >= {1'b0, root_in});
            if (qbit)
            begin
                rem_n = ROOT_W'(rem_sh - {1'b0, root_in});
            end
            else
            begin
                rem_n = rem_sh[ROOT_W-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                last_reg[s] <= last_in;
                flag_reg[s] <= flag_in;
                root_reg[s] <= root_in;
                rem_reg[s]  <= rem_n;
                low_reg[s]  <= low_in << 1;
                q_reg[s]    <= {q_in[DW-2:0], qbit};
            end
        end
    end

    // The last stage is the output register.
    assign out_item.valid = v_reg[DIV_STAGES-1];
    assign out_item.last  = last_reg[DIV_STAGES-1];
    assign out_item.flag  = flag_reg[DIV_STAGES-1];
    assign out_item.err   = flag_reg[DIV_STAGES-1] ? '1 : q_reg[DIV_STAGES-1];

endmodule

FILE: hdl/sefp_checker.sv
`include "sampson_error_from_parameters_assert.svh"

module sefp_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [127:0] s_axis_tdata,
    input logic         s_axis_tlast,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [31:0]  m_axis_tdata,
    input logic         m_axis_tuser,
    input logic         m_axis_tlast,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic [3:0]   cfg_index,
    input logic [31:0]  cfg_data
);

    // A result waiting for transfer keeps its payload.
    `SEFP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

    // A degenerate result always carries the saturated value.
    `SEFP_ASSERT_NOW(a_flag_sat, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 32'hFFFFFFFF, "flagged result not saturated")

    // The frozen pipeline takes no new item.
    `SEFP_ASSERT_NOW(a_stall_in, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while output stalled")

    // A register write holds off input while the matrix is rebuilt.
    `SEFP_ASSERT_NEXT(a_cfg_settle, cfg_valid && cfg_ready, !s_axis_tready, "input taken during matrix rebuild")

endmodule

bind sampson_error_from_parameters sefp_checker u_sefp_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import sefp_pkg::*;

    // Index outside the register file; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int LONG_STALL     = 400;
    localparam int NUM_SETTINGS   = 12;
    localparam int ITEMS_PER_SET  = 119;

    typedef struct {
        logic [127:0] data;
        logic         last;
    } pair_t;

    typedef struct {
        logic [31:0] err;
        logic        flag;
        logic        last;
    } dist_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [127:0]          s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DW-1:0]         m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [DW-1:0]         cfg_data = '0;

    pair_t        pair_q[$];
    dist_t        dist_q[$];
    logic signed [31:0] cfg_mirror[8];
    int           tx_idle = 0;
    int           rx_idle = 0;
    bit           hold_send = 1'b0;
    int           stall_req = 0;
    int           stall_seen = 0;
    int           stall_left = 0;
    int           presented = 0;
    int           accepted = 0;
    int           mismatches = 0;
    int           quiet_cycles = 0;

    sampson_error_from_parameters dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Floor an exact product sum to the fixed-point grid and saturate it.
    function automatic logic signed [31:0] floor_sat(input logic signed [127:0] s,
                                                      inout logic sat);
        logic signed [127:0] f;
        f = s >>> FRAC_BITS;
        if (f > 128'sh7FFFFFFF)
        begin
            sat = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (f < -128'sh80000000)
        begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return f[31:0];
    endfunction

    // Rebuild the fundamental matrix and compute the Sampson distance of one pair.
    function automatic dist_t sampson_distance(input logic [127:0] d, input logic last);
        logic signed [127:0] x0, y0, x1, y1, one, rw1, rw2, cw1, cw2;
        logic signed [127:0] fm[9];
        logic signed [127:0] mn[4];
        logic signed [127:0] l1[3];
        logic signed [127:0] l0[2];
        logic signed [127:0] num;
        logic [127:0] rad, root, bitv, anum, qq;
        logic [7:0] pos;
        int id, jd, ur, uc, n, k, nx, r, c;
        int rr[2];
        int cc[2];
        logic sat;
        dist_t res;
        x0 = $signed(d[31:0]);
        y0 = $signed(d[63:32]);
        x1 = $signed(d[95:64]);
        y1 = $signed(d[127:96]);
        one = 128'sd1 <<< FRAC_BITS;
        rw1 = cfg_mirror[3];
        rw2 = cfg_mirror[4];
        cw1 = cfg_mirror[5];
        cw2 = cfg_mirror[6];
        pos = cfg_mirror[7][7:0];
        id = pos[1:0];
        jd = pos[3:2];
        ur = pos[5:4];
        uc = pos[7:6];
        // A dependent position code of 3 acts as 2.
        if (id > 2) id = 2;
        if (jd > 2) jd = 2;
        n = 0;
        for (k = 0; k < 3; k++) if (k != id) begin rr[n] = k; n++; end
        n = 0;
        for (k = 0; k < 3; k++) if (k != jd) begin cc[n] = k; n++; end
        sat = 1'b0;
        nx = 0;
        // Minor: unit slot holds one, the others take the free registers (then ROW_W1) in turn.
        for (k = 0; k < 4; k++)
        begin
            r = rr[k >> 1];
            c = cc[k & 1];
            if (r == ur && c == uc)
            begin
                mn[k] = one;
            end
            else
            begin
                mn[k] = cfg_mirror[nx];
                nx++;
            end
            fm[r * 3 + c] = mn[k];
        end
        fm[rr[0] * 3 + jd] = floor_sat(-(mn[0] * rw1 + mn[1] * rw2), sat);
        fm[rr[1] * 3 + jd] = floor_sat(-(mn[2] * rw1 + mn[3] * rw2), sat);
        fm[id * 3 + cc[0]] = floor_sat(-(mn[0] * cw1 + mn[2] * cw2), sat);
        fm[id * 3 + cc[1]] = floor_sat(-(mn[1] * cw1 + mn[3] * cw2), sat);
        fm[id * 3 + jd] = floor_sat(-(fm[id * 3 + cc[0]] * rw1
                                     + fm[id * 3 + cc[1]] * rw2), sat);
        // Epipolar lines and the algebraic residual.
        for (k = 0; k < 3; k++)
            l1[k] = floor_sat(fm[k * 3] * x0 + fm[k * 3 + 1] * y0 + fm[k * 3 + 2] * one, sat);
        for (k = 0; k < 2; k++)
            l0[k] = floor_sat(fm[k] * x1 + fm[3 + k] * y1 + fm[6 + k] * one, sat);
        num = floor_sat(x1 * l1[0] + y1 * l1[1] + one * l1[2], sat);
        rad = l0[0] * l0[0] + l0[1] * l0[1] + l1[0] * l1[0] + l1[1] * l1[1];
        // Floor integer square root, two radicand bits per step.
        root = 0;
        for (k = 34; k >= 0; k--)
        begin
            bitv = 128'd1 << (2 * k);
            if (rad >= root + bitv)
            begin
                rad = rad - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
        end
        anum = (num < 0) ? -num : num;
        res.flag = sat || (root == 0);
        res.err = 32'hFFFFFFFF;
        if (!res.flag)
        begin
            qq = (anum << FRAC_BITS) / root;
            if (qq > 128'hFFFFFFFF) res.flag = 1'b1;
            else res.err = qq[31:0];
        end
        res.last = last;
        return res;
    endfunction

    // Sender: holds an item until its transfer, then offers the next or idles.
    always @(negedge clk)
    begin
        if (!(s_axis_tvalid && accepted < presented))
        begin
            if (pair_q.size() > 0 && !hold_send && $urandom_range(99) >= tx_idle)
            begin
                s_axis_tdata  <= pair_q[0].data;
                s_axis_tlast  <= pair_q[0].last;
                s_axis_tvalid <= 1'b1;
                void'(pair_q.pop_front());
                presented <= presented + 1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request.
    always @(negedge clk)
    begin
        if (stall_req != stall_seen)
        begin
            stall_seen    <= stall_req;
            stall_left    <= LONG_STALL;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // Input transfers feed the predictor; output transfers are checked.
    always @(posedge clk)
    begin
        dist_t want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            dist_q.push_back(sampson_distance(s_axis_tdata, s_axis_tlast));
            accepted <= accepted + 1;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (dist_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: err=%h flag=%b last=%b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                want = dist_q.pop_front();
                if (m_axis_tdata !== want.err || m_axis_tuser !== want.flag
                    || m_axis_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected err=%h flag=%b last=%b, got err=%h flag=%b last=%b",
                                 want.err, want.flag, want.last,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready) || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** sampson_error_from_parameters: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            6: return $urandom;
            7: return 32'h7FFFFFFF;
            8: return 32'h80000000;
            9: return $urandom_range(32'h1FFFF) - 32'h10000;
            default: return $urandom_range(32'h1FFFFFF) - 32'h1000000;
        endcase
    endfunction

    function automatic logic [31:0] rand_param();
        case ($urandom_range(7))
            0: return $urandom;
            1: return 32'h0;
            default: return $urandom_range(32'h7FFFF) - 32'h40000;
        endcase
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        p.data = {rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        p.last = $urandom_range(1);
        return p;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == REG_POSITIONS) cfg_mirror[7] = {24'd0, val[7:0]};
        else if (idx < 8) cfg_mirror[idx] = val;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pair_q.size() > 0 || s_axis_tvalid || dist_q.size() > 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic apply_setting(input int s);
        logic [31:0] v[8];
        for (int k = 0; k < 7; k++) v[k] = rand_param();
        v[7] = $urandom_range(255);
        case (s)
            0: for (int k = 0; k < 7; k++) v[k] = 32'h7FFFFFFF;
            1: for (int k = 0; k < 7; k++) v[k] = 32'h80000000;
            // Dependent row and column codes of 3.
            2: v[7] = 8'hFF;
            // Unit slot on the dependent row, so no minor slot holds one.
            3: v[7] = 8'h00;
            4: v[7] = POS_RESET;
            default: ;
        endcase
        write_reg(REG_FREE_A, v[0]);
        write_reg(REG_FREE_B, v[1]);
        write_reg(REG_FREE_C, v[2]);
        write_reg(REG_ROW_W1, v[3]);
        write_reg(REG_ROW_W2, v[4]);
        write_reg(REG_COL_W1, v[5]);
        write_reg(REG_COL_W2, v[6]);
        write_reg(REG_POSITIONS, v[7]);
        if (s == 3) write_reg(REG_UNUSED, $urandom);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Test sequence.
    initial
    begin
        logic [31:0] corner[6];
        pair_t p;
        corner = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, 32'hFFFF0000, 32'h00008000};
        for (int k = 0; k < 7; k++) cfg_mirror[k] = 0;
        cfg_mirror[7] = {24'd0, POS_RESET};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed pairs under the reset matrix: field extremes and both frame marks.
        for (int k = 0; k < 24; k++)
        begin
            p.data = {corner[(k / 6) % 6], corner[(k + 2) % 6], corner[(k / 4) % 6], corner[k % 6]};
            p.last = k[0];
            pair_q.push_back(p);
        end
        wait_drained();

        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            tx_idle = (s < 4) ? 37 : (s < 8) ? 77 : 0;
            rx_idle = (s < 4) ? 77 : (s < 8) ? 37 : 0;
            apply_setting(s);
            for (int k = 0; k < ITEMS_PER_SET; k++) pair_q.push_back(rand_pair());
            if (s == 5)
            begin
                // Long receiver hold-off while the sender keeps offering.
                stall_req = stall_req + 1;
            end
            if (s == 9)
            begin
                // Sender pause until the pipeline has fully drained.
                while (pair_q.size() > ITEMS_PER_SET / 2) @(posedge clk);
                hold_send = 1'b1;
                @(posedge clk);
                while (s_axis_tvalid || dist_q.size() > 0) @(posedge clk);
                hold_send = 1'b0;
            end
            wait_drained();
        end

        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("** sampson_error_from_parameters: PASSED **");
        else
            $display("** sampson_error_from_parameters: FAILED **");
        $finish;
    end

endmodule
